/* hw/rtl/sccr_pkg.sv */
// Shared types and constants of the sector cache directory with clock replacement.
`default_nettype none

package sccr_pkg;

   // Default slot count of the directory
   localparam int CACHE_ENTRIES_DEF = 64;

   // Fixed field widths of the request and response beats
   localparam int SECTOR_W = 32;
   localparam int SLOT_W   = 6;

   // Request type codes
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Response beat handed from the sequencer to the output register
   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic                fill_needed;
      logic                writeback_needed;
      logic [SECTOR_W-1:0] writeback_sector;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/sccr_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module sccr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/sccr_ctrl.sv */
// Sequencer: tag search, clock sweep, victim read and order-list shift over two RAMs.
`default_nettype none

module sccr_ctrl #(
   parameter int CACHE_ENTRIES = sccr_pkg::CACHE_ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_type,
   input  wire logic [sccr_pkg::SECTOR_W-1:0]  req_sector,
   input  wire logic                           rsp_free,
   output logic                                rsp_load,
   output sccr_pkg::rsp_type                   rsp_beat
);

   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_SWEEP  = 3'd2;
   localparam logic [2:0] ST_VICTIM = 3'd3;
   localparam logic [2:0] ST_SHIFT  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic                          is_write_ff, is_write_in;
   logic [sccr_pkg::SECTOR_W-1:0] sector_ff, sector_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [IDX_W-1:0]              slot_ff, slot_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          hit_ff, hit_in;
   logic                          wb_ff, wb_in;
   logic [sccr_pkg::SECTOR_W-1:0] wb_sector_ff, wb_sector_in;
   logic [CACHE_ENTRIES-1:0]      accessed_ff, accessed_in;
   logic [CACHE_ENTRIES-1:0]      dirty_ff, dirty_in;

   // RAM ports
   logic                          tag_wr_en;
   logic [IDX_W-1:0]              tag_wr_addr;
   logic [IDX_W-1:0]              tag_rd_addr;
   logic [sccr_pkg::SECTOR_W-1:0] tag_rd_data;
   logic                          ord_wr_en;
   logic [IDX_W-1:0]              ord_wr_addr;
   logic [IDX_W-1:0]              ord_wr_data;
   logic [IDX_W-1:0]              ord_rd_addr;
   logic [IDX_W-1:0]              ord_rd_data;

   logic accept;
   logic last_idx;

   sccr_ram #(
      .WIDTH (sccr_pkg::SECTOR_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (sector_ff),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   sccr_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_addr (ord_rd_addr),
      .rd_data (ord_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign last_idx  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // Advance the sequencer
   always_comb begin
      state_in     = state_ff;
      is_write_in  = is_write_ff;
      sector_in    = sector_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      wb_in        = wb_ff;
      wb_sector_in = wb_sector_ff;
      accessed_in  = accessed_ff;
      dirty_in     = dirty_ff;
      tag_wr_en    = 1'b0;
      tag_wr_addr  = slot_ff;
      ord_wr_en    = 1'b0;
      ord_wr_addr  = idx_ff;
      ord_wr_data  = ord_rd_data;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               is_write_in  = (req_type == sccr_pkg::REQ_WRITE);
               sector_in    = req_sector;
               idx_in       = '0;
               hit_in       = 1'b0;
               wb_in        = 1'b0;
               wb_sector_in = '0;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (count_ff != '0 && tag_rd_data == sector_ff) begin
               // Hit: mark the slot
               hit_in               = 1'b1;
               slot_in              = idx_ff;
               accessed_in[idx_ff]  = 1'b1;
               if (is_write_ff) begin
                  dirty_in[idx_ff] = 1'b1;
               end
               state_in = ST_FINISH;
            end else if (count_ff == '0 || last_idx) begin
               if (count_ff != CNT_W'(CACHE_ENTRIES)) begin
                  // Miss with a free slot: fill the next one
                  slot_in              = count_ff[IDX_W-1:0];
                  idx_in               = count_ff[IDX_W-1:0];
                  tag_wr_en            = 1'b1;
                  tag_wr_addr          = count_ff[IDX_W-1:0];
                  accessed_in[count_ff[IDX_W-1:0]] = 1'b1;
                  dirty_in[count_ff[IDX_W-1:0]]    = is_write_ff;
                  count_in             = count_ff + CNT_W'(1);
                  state_in             = ST_SHIFT;
               end else begin
                  // Miss on a full directory: sweep from the newest entry
                  idx_in   = '0;
                  state_in = ST_SWEEP;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SWEEP: begin
            if (!accessed_ff[ord_rd_data]) begin
               slot_in  = ord_rd_data;
               state_in = ST_VICTIM;
            end else begin
               accessed_in[ord_rd_data] = 1'b0;
               idx_in = (idx_ff == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : idx_ff + IDX_W'(1);
            end
         end
         ST_VICTIM: begin
            // Report a dirty victim and install the new tag
            if (dirty_ff[slot_ff]) begin
               wb_in        = 1'b1;
               wb_sector_in = tag_rd_data;
            end
            tag_wr_en            = 1'b1;
            accessed_in[slot_ff] = 1'b1;
            dirty_in[slot_ff]    = is_write_ff;
            state_in             = ST_SHIFT;
         end
         ST_SHIFT: begin
            ord_wr_en = 1'b1;
            if (idx_ff == '0) begin
               ord_wr_data = slot_ff;
               state_in    = ST_FINISH;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read addresses follow the next index; the tag RAM reads the victim slot and the shift reads one entry below
   always_comb begin
      tag_rd_addr = (state_in == ST_VICTIM) ? slot_in : idx_in;
      ord_rd_addr = (state_in == ST_SHIFT) ? idx_in - IDX_W'(1) : idx_in;
   end

   // Build the response beat
   always_comb begin
      rsp_beat.hit              = hit_ff;
      rsp_beat.slot             = sccr_pkg::SLOT_W'(slot_ff);
      rsp_beat.fill_needed      = !hit_ff && !is_write_ff;
      rsp_beat.writeback_needed = wb_ff;
      rsp_beat.writeback_sector = wb_sector_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         accessed_ff <= '0;
         dirty_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         accessed_ff <= accessed_in;
         dirty_ff    <= dirty_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      is_write_ff  <= is_write_in;
      sector_ff    <= sector_in;
      idx_ff       <= idx_in;
      slot_ff      <= slot_in;
      hit_ff       <= hit_in;
      wb_ff        <= wb_in;
      wb_sector_ff <= wb_sector_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/sector_cache_clock_replacement_top.sv */
// Sector cache directory with clock replacement: sequencer plus response register.
// Each request is searched in the tag RAM; a miss fills a free slot, or when full sweeps
// for a victim and reads it; the order list is then shifted. A new request is taken only
// after the response is loaded, which waits while a full response register is stalled.
// Reset clears the state, the fill count and all accessed and dirty bits.
`default_nettype none

module sector_cache_clock_replacement_top #(
   parameter int CACHE_ENTRIES = sccr_pkg::CACHE_ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_type,
   input  wire logic [sccr_pkg::SECTOR_W-1:0]  req_sector,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_hit,
   output logic      [sccr_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                                rsp_fill_needed,
   output logic                                rsp_writeback_needed,
   output logic      [sccr_pkg::SECTOR_W-1:0]  rsp_writeback_sector
);

   logic              rsp_valid_ff, rsp_valid_in;
   sccr_pkg::rsp_type rsp_ff;
   sccr_pkg::rsp_type rsp_beat;
   logic              rsp_load;
   logic              rsp_free;

   sccr_ctrl #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_type   (req_type),
      .req_sector (req_sector),
      .rsp_free   (rsp_free),
      .rsp_load   (rsp_load),
      .rsp_beat   (rsp_beat)
   );

   // Output register is free when empty or drained this cycle
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the beat until taken
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_beat;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_ff.hit;
   assign rsp_slot             = rsp_ff.slot;
   assign rsp_fill_needed      = rsp_ff.fill_needed;
   assign rsp_writeback_needed = rsp_ff.writeback_needed;
   assign rsp_writeback_sector = rsp_ff.writeback_sector;

   // A request is never accepted back to back with the one before
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sequencer took back-to-back requests");

   // A hit never asks for a fill or a writeback
   a_hit_no_miss_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_fill_needed && !rsp_writeback_needed)
      else $error("hit response carries miss work");

   // No writeback means a zero writeback sector
   a_wb_sector_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_writeback_needed |-> rsp_writeback_sector == '0)
      else $error("writeback sector set without writeback");

   // A new beat is loaded only into a free output register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || !rsp_stall)
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench of the sector cache directory with clock replacement.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES    = sccr_pkg::CACHE_ENTRIES_DEF;
   localparam int DIR_ROWS   = 14;
   localparam int POOL_SIZE  = 128;
   localparam int HOT_SIZE   = 16;
   localparam int PHASE_REQS = 185;
   localparam int HOLD_BEATS = 300;
   localparam int DRAIN_WAIT = 300;

   // One row of the directed stimulus; want is used only when known is set
   typedef struct {
      logic                          typ;
      logic [sccr_pkg::SECTOR_W-1:0] sector;
      bit                            known;
      sccr_pkg::rsp_type             want;
   } dir_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_type = sccr_pkg::REQ_READ;
   logic [sccr_pkg::SECTOR_W-1:0] req_sector = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_hit;
   logic [sccr_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          rsp_fill_needed;
   logic                          rsp_writeback_needed;
   logic [sccr_pkg::SECTOR_W-1:0] rsp_writeback_sector;

   // Shadow copy of the directory
   logic [sccr_pkg::SECTOR_W-1:0] dir_tag [ENTRIES];
   logic                          dir_accessed [ENTRIES];
   logic                          dir_dirty [ENTRIES];
   logic [sccr_pkg::SLOT_W-1:0]   dir_order [ENTRIES];
   int                            dir_fill;

   sccr_pkg::rsp_type             pending_lookups[$];
   int                            mismatch_count = 0;
   int                            sender_idle_pct = 0;
   int                            rsp_stall_pct = 0;
   int                            hold_request = 0;
   int                            hold_count = 0;
   logic [sccr_pkg::SECTOR_W-1:0] sector_pool [POOL_SIZE];
   dir_row_type                   dir_rows [DIR_ROWS];

   sector_cache_clock_replacement_top #(
      .CACHE_ENTRIES(ENTRIES)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_sector           (req_sector),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hit              (rsp_hit),
      .rsp_slot             (rsp_slot),
      .rsp_fill_needed      (rsp_fill_needed),
      .rsp_writeback_needed (rsp_writeback_needed),
      .rsp_writeback_sector (rsp_writeback_sector)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Look up one sector in the shadow directory and update it as the block should
   function automatic sccr_pkg::rsp_type cache_lookup(input logic wr,
                                                      input logic [sccr_pkg::SECTOR_W-1:0] sec);
      sccr_pkg::rsp_type r;
      int                i;
      int                found;
      int                pos;
      int                victim;
      int                steps;
      r = '0;
      found = -1;
      for (i = 0; i < dir_fill; i++) begin
         if (found < 0 && dir_tag[dir_order[i]] == sec) found = dir_order[i];
      end
      if (found >= 0) begin
         r.hit = 1'b1;
         r.slot = found[sccr_pkg::SLOT_W-1:0];
         dir_accessed[found] = 1'b1;
         if (wr == sccr_pkg::REQ_WRITE) dir_dirty[found] = 1'b1;
      end else begin
         if (dir_fill < ENTRIES) begin
            victim = dir_fill;
            pos = dir_fill;
            dir_fill++;
         end else begin
            // sweep from the newest entry, clearing accessed bits on the way
            pos = 0;
            for (steps = 0; steps < 2 * ENTRIES + 1 && dir_accessed[dir_order[pos]];
                 steps++) begin
               dir_accessed[dir_order[pos]] = 1'b0;
               pos = (pos + 1) % ENTRIES;
            end
            victim = dir_order[pos];
            if (dir_dirty[victim]) begin
               r.writeback_needed = 1'b1;
               r.writeback_sector = dir_tag[victim];
            end
         end
         // move the new entry to the front of the order
         for (i = pos; i > 0; i--) dir_order[i] = dir_order[i - 1];
         dir_order[0] = victim[sccr_pkg::SLOT_W-1:0];
         dir_tag[victim] = sec;
         dir_accessed[victim] = 1'b1;
         dir_dirty[victim] = (wr == sccr_pkg::REQ_WRITE);
         r.slot = victim[sccr_pkg::SLOT_W-1:0];
         r.fill_needed = (wr == sccr_pkg::REQ_READ);
      end
      return r;
   endfunction

   // Offer one request beat, hold it until accepted, then queue its expected response
   task automatic send_req(input logic t, input logic [sccr_pkg::SECTOR_W-1:0] s,
                           input bit known, input sccr_pkg::rsp_type typed);
      sccr_pkg::rsp_type want;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= t;
      req_sector <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = cache_lookup(t, s);
      if (known) want = typed;
      pending_lookups.push_back(want);
   endtask

   // Draw a request from a working set or a hot subset, sometimes noise
   task automatic send_random(input int wset);
      logic                          t;
      logic [sccr_pkg::SECTOR_W-1:0] s;
      t = ($urandom_range(99) < 40) ? sccr_pkg::REQ_WRITE : sccr_pkg::REQ_READ;
      if ($urandom_range(99) < 12) s = $urandom;
      else if ($urandom_range(1) == 1) s = sector_pool[$urandom_range(HOT_SIZE - 1)];
      else s = sector_pool[$urandom_range(wset - 1)];
      send_req(t, s, 1'b0, '0);
   endtask

   // Drop valid and wait until every expected response has come back
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [sccr_pkg::SECTOR_W-1:0] want,
                              input logic [sccr_pkg::SECTOR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: long hold-off on request, else random stalls
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_count = hold_request;
         hold_request = 0;
      end
      if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count = hold_count - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compare each accepted response beat with the oldest expectation
   always @(posedge clock) begin
      sccr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual hit %0b slot %0d",
                     $time, rsp_hit, rsp_slot);
            mismatch_count++;
         end else begin
            want = pending_lookups.pop_front();
            check_field("hit", sccr_pkg::SECTOR_W'(want.hit),
                        sccr_pkg::SECTOR_W'(rsp_hit));
            check_field("slot", sccr_pkg::SECTOR_W'(want.slot),
                        sccr_pkg::SECTOR_W'(rsp_slot));
            check_field("fill_needed", sccr_pkg::SECTOR_W'(want.fill_needed),
                        sccr_pkg::SECTOR_W'(rsp_fill_needed));
            check_field("writeback_needed", sccr_pkg::SECTOR_W'(want.writeback_needed),
                        sccr_pkg::SECTOR_W'(rsp_writeback_needed));
            check_field("writeback_sector", want.writeback_sector, rsp_writeback_sector);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      int phase;
      int k;
      int wset;
      int idle_by_phase [4];
      int stall_by_phase [4];

      idle_by_phase  = '{0, 86, 0, 22};
      stall_by_phase = '{0, 0, 86, 22};

      // empty shadow directory
      dir_fill = 0;
      for (k = 0; k < ENTRIES; k++) begin
         dir_tag[k] = '0;
         dir_accessed[k] = 1'b0;
         dir_dirty[k] = 1'b0;
         dir_order[k] = '0;
      end

      // working set, with the all-zero and all-one sectors in the hot part
      sector_pool[0] = '0;
      sector_pool[1] = '1;
      for (k = 2; k < POOL_SIZE; k++) sector_pool[k] = $urandom;

      // fill from empty, hits on both extremes, read and write hits and misses
      dir_rows[0]  = '{sccr_pkg::REQ_READ,  32'h0000_0000, 1'b1,
                       '{1'b0, 6'd0, 1'b1, 1'b0, 32'h0}};
      dir_rows[1]  = '{sccr_pkg::REQ_WRITE, 32'hFFFF_FFFF, 1'b1,
                       '{1'b0, 6'd1, 1'b0, 1'b0, 32'h0}};
      dir_rows[2]  = '{sccr_pkg::REQ_READ,  32'h0000_0000, 1'b1,
                       '{1'b1, 6'd0, 1'b0, 1'b0, 32'h0}};
      dir_rows[3]  = '{sccr_pkg::REQ_WRITE, 32'h0000_0000, 1'b1,
                       '{1'b1, 6'd0, 1'b0, 1'b0, 32'h0}};
      dir_rows[4]  = '{sccr_pkg::REQ_READ,  32'hFFFF_FFFF, 1'b1,
                       '{1'b1, 6'd1, 1'b0, 1'b0, 32'h0}};
      dir_rows[5]  = '{sccr_pkg::REQ_WRITE, 32'h0000_0001, 1'b1,
                       '{1'b0, 6'd2, 1'b0, 1'b0, 32'h0}};
      dir_rows[6]  = '{sccr_pkg::REQ_READ,  32'h8000_0000, 1'b1,
                       '{1'b0, 6'd3, 1'b1, 1'b0, 32'h0}};
      dir_rows[7]  = '{sccr_pkg::REQ_WRITE, 32'h7FFF_FFFF, 1'b1,
                       '{1'b0, 6'd4, 1'b0, 1'b0, 32'h0}};
      dir_rows[8]  = '{sccr_pkg::REQ_READ,  32'h0000_0001, 1'b1,
                       '{1'b1, 6'd2, 1'b0, 1'b0, 32'h0}};
      dir_rows[9]  = '{sccr_pkg::REQ_WRITE, 32'h8000_0000, 1'b0, '0};
      dir_rows[10] = '{sccr_pkg::REQ_READ,  32'hA5A5_A5A5, 1'b0, '0};
      dir_rows[11] = '{sccr_pkg::REQ_WRITE, 32'h5A5A_5A5A, 1'b0, '0};
      dir_rows[12] = '{sccr_pkg::REQ_READ,  32'hA5A5_A5A5, 1'b0, '0};
      dir_rows[13] = '{sccr_pkg::REQ_WRITE, 32'hFFFF_FFFF, 1'b0, '0};

      // hold reset at the start
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIR_ROWS; k++) begin
         send_req(dir_rows[k].typ, dir_rows[k].sector, dir_rows[k].known, dir_rows[k].want);
      end

      // random phases, each with its own idling mix; drain between phases
      wset = HOT_SIZE;
      for (phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_by_phase[phase];
         rsp_stall_pct   = stall_by_phase[phase];
         for (k = 0; k < PHASE_REQS; k++) begin
            if (phase == 0 && k == 90) hold_request = HOLD_BEATS;
            if (k % 32 == 0) wset = $urandom_range(POOL_SIZE, 40);
            send_random(wset);
         end
         drain();
      end

      // let any stray response show up
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/sccr_pkg.sv
hw/rtl/sccr_ram.sv
hw/rtl/sccr_ctrl.sv
hw/rtl/sector_cache_clock_replacement_top.sv
verif/tb_top.sv
